/* rtl/core/gpa_pkg.sv */
package gpa_pkg;

    // defaults for the top-level parameters
    localparam int MAX_RING_VERTICES_DEF = 1024;
    localparam int COS_TABLE_ENTRIES_DEF = 256;

    // ring record widths, sized for the largest ring the block supports
    localparam int REC_CNT_W = 17;
    localparam int REC_LAT_W = 48;
    localparam int QUEUE_DEPTH = 4;

    // a ring needs this many vertices to enclose any area
    localparam int MIN_RING_VERTICES = 3;

    // angles in units of 2^-23 degree
    localparam logic [31:0] DEG90 = 32'd754974720;
    localparam logic [31:0] DEG180 = 32'd1509949440;
    // 90 degrees is 45 * 2^24
    localparam int DEG90_ODD = 45;
    localparam int FRAC_SHIFT = 24;

    // 111320^2 square metres per square degree
    localparam logic [33:0] DEG_M_SQ = 34'd12392142400;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [55:0] TOTAL_MAX = '1;

    typedef enum logic [0:0] {
        REQ_VERTEX = 1'b0,
        REQ_END    = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] vertex_lon;
        logic signed [31:0] vertex_lat;
        logic               ring_last;
    } req_word_t;

    typedef struct packed {
        logic [55:0] area_sq_m;
        logic        area_saturated;
    } rsp_word_t;

    // one closed ring or one end of polygon, front to back
    typedef struct packed {
        logic                        is_end;
        logic                        sat;
        logic signed [63:0]          cross_sum;
        logic signed [REC_LAT_W-1:0] lat_sum;
        logic [REC_CNT_W-1:0]        count;
    } ring_rec_t;

endpackage

/* rtl/core/gpa_stream_if.sv */
interface gpa_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/gpa_front.sv */
module gpa_front #(
    parameter int MAX_RING_VERTICES = gpa_pkg::MAX_RING_VERTICES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    gpa_stream_if.sink        req,
    input  logic              q_full,
    output logic              push,
    output gpa_pkg::ring_rec_t push_rec
);
    import gpa_pkg::*;

    localparam int CNT_W = $clog2(MAX_RING_VERTICES + 1);
    localparam int LAT_W = 32 + CNT_W;

    typedef struct packed {
        logic                    add;
        logic                    close;
        logic                    is_end;
        logic                    sat;
        logic signed [31:0]      pl;
        logic signed [31:0]      pt;
        logic signed [31:0]      rl;
        logic signed [31:0]      rt;
        logic signed [LAT_W-1:0] lat;
        logic [CNT_W-1:0]        cnt;
    } s1_t;

    typedef struct packed {
        logic                    add;
        logic                    close;
        logic                    is_end;
        logic                    sat;
        logic signed [63:0]      p1;
        logic signed [63:0]      p2;
        logic signed [LAT_W-1:0] lat;
        logic [CNT_W-1:0]        cnt;
    } s2_t;

    logic signed [31:0]      first_lon_reg, first_lat_reg;
    logic signed [31:0]      prev_lon_reg, prev_lat_reg;
    logic signed [LAT_W-1:0] lat_sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [63:0]      cross_reg;
    logic                    psat_reg;
    logic                    s1_valid_reg, s2_valid_reg;
    s1_t                     s1_reg, s1_next;
    s2_t                     s2_reg, s2_next;

    logic                    en, accept, is_end, drop, add;
    logic signed [31:0]      first_lon, first_lat, rl, rt;
    logic signed [32:0]      dl, dt;
    logic                    sat_l, sat_t;
    logic signed [LAT_W-1:0] lat_next;
    logic signed [64:0]      sum65;
    logic signed [63:0]      d, cross_new, cross_after;
    logic                    ovf, psat_after;

    assign en = !q_full;
    assign req.ready = en;
    assign accept = req.valid && en;

    // stage 1: relative coordinates, latitude sum, vertex count
    always_comb
    begin
        is_end = req.data.req_type == REQ_END;
        drop = cnt_reg >= CNT_W'(MAX_RING_VERTICES);
        add = !is_end && !drop;
        first_lon = (cnt_reg == '0) ? req.data.vertex_lon : first_lon_reg;
        first_lat = (cnt_reg == '0) ? req.data.vertex_lat : first_lat_reg;
        dl = {req.data.vertex_lon[31], req.data.vertex_lon} - {first_lon[31], first_lon};
        dt = {req.data.vertex_lat[31], req.data.vertex_lat} - {first_lat[31], first_lat};
        sat_l = dl[32] != dl[31];
        sat_t = dt[32] != dt[31];
        rl = sat_l ? (dl[32] ? 32'sh80000000 : 32'sh7fffffff) : dl[31:0];
        rt = sat_t ? (dt[32] ? 32'sh80000000 : 32'sh7fffffff) : dt[31:0];
        lat_next = lat_sum_reg
            + {{(LAT_W - 32){req.data.vertex_lat[31]}}, req.data.vertex_lat};

        s1_next.add = add;
        s1_next.close = !is_end && req.data.ring_last;
        s1_next.is_end = is_end;
        s1_next.sat = !is_end && (drop || sat_l || sat_t);
        s1_next.pl = prev_lon_reg;
        s1_next.pt = prev_lat_reg;
        s1_next.rl = rl;
        s1_next.rt = rt;
        s1_next.lat = add ? lat_next : lat_sum_reg;
        s1_next.cnt = add ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    // stage 2: the two cross products
    always_comb
    begin
        s2_next.add = s1_reg.add;
        s2_next.close = s1_reg.close;
        s2_next.is_end = s1_reg.is_end;
        s2_next.sat = s1_reg.sat;
        s2_next.p1 = s1_reg.pl * s1_reg.rt;
        s2_next.p2 = s1_reg.rl * s1_reg.pt;
        s2_next.lat = s1_reg.lat;
        s2_next.cnt = s1_reg.cnt;
    end

    // accumulate: saturating cross sum, record out on ring close or end
    always_comb
    begin
        d = s2_reg.p1 - s2_reg.p2;
        sum65 = {cross_reg[63], cross_reg} + {d[63], d};
        ovf = sum65[64] != sum65[63];
        cross_new = ovf ? (sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum65[63:0];
        cross_after = s2_reg.add ? cross_new : cross_reg;
        psat_after = psat_reg || s2_reg.sat || (s2_reg.add && ovf);

        push = en && s2_valid_reg && (s2_reg.close || s2_reg.is_end);
        push_rec.is_end = s2_reg.is_end;
        push_rec.sat = psat_after;
        push_rec.cross_sum = cross_after;
        push_rec.lat_sum = REC_LAT_W'(s2_reg.lat);
        push_rec.count = REC_CNT_W'(s2_reg.cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_lon_reg <= '0;
            first_lat_reg <= '0;
            prev_lon_reg <= '0;
            prev_lat_reg <= '0;
            lat_sum_reg <= '0;
            cnt_reg <= '0;
            cross_reg <= '0;
            psat_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (is_end || req.data.ring_last)
                begin
                    first_lon_reg <= '0;
                    first_lat_reg <= '0;
                    prev_lon_reg <= '0;
                    prev_lat_reg <= '0;
                    lat_sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else if (add)
                begin
                    first_lon_reg <= first_lon;
                    first_lat_reg <= first_lat;
                    prev_lon_reg <= rl;
                    prev_lat_reg <= rt;
                    lat_sum_reg <= lat_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (en)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
                if (s2_valid_reg)
                begin
                    cross_reg <= (s2_reg.close || s2_reg.is_end) ? '0 : cross_after;
                    psat_reg <= s2_reg.is_end ? 1'b0 : psat_after;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

endmodule

/* rtl/core/gpa_queue.sv */
module gpa_queue #(
    parameter int DEPTH = gpa_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gpa_pkg::ring_rec_t push_rec,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output gpa_pkg::ring_rec_t pop_rec
);
    import gpa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ring_rec_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full = cnt_reg == CNT_W'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_rec = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

/* rtl/core/gpa_divider.sv */
module gpa_divider #(
    parameter int N_W = gpa_pkg::REC_LAT_W,
    parameter int D_W = gpa_pkg::REC_CNT_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);
    localparam int C_W = $clog2(N_W + 1);

    logic [N_W-1:0] q_reg;
    logic [D_W-1:0] r_reg, d_reg;
    logic [C_W-1:0] cnt_reg;
    logic           busy_reg, done_reg;
    logic [D_W:0]   r_sh, r_sub;
    logic           ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        r_sh = {r_reg, q_reg[N_W-1]};
        ge = r_sh >= {1'b0, d_reg};
        r_sub = r_sh - {1'b0, d_reg};
    end

    assign done = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= C_W'(N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - C_W'(1);
                if (cnt_reg == C_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[N_W-2:0], ge};
            r_reg <= ge ? r_sub[D_W-1:0] : r_sh[D_W-1:0];
        end
    end

endmodule

/* rtl/core/gpa_back.sv */
module gpa_back #(
    parameter int COS_ENTRIES = gpa_pkg::COS_TABLE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  gpa_pkg::ring_rec_t q_rec,
    output logic               q_pop,
    gpa_stream_if.source       rsp
);
    import gpa_pkg::*;

    localparam int COS_W = 31;
    localparam int IDX_W = $clog2(COS_ENTRIES + 1);
    localparam int T_W = 30 + IDX_W;
    localparam int TAB_W = (COS_ENTRIES + 1) * COS_W;
    localparam logic [63:0] TAYLOR_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };
    // x / 45 as (x * RECIP45) >> 37, exact for x below 3.19e9
    localparam logic [31:0] RECIP45 = 32'd3054198967;
    localparam int RECIP_SHIFT = 37;

    localparam logic [2:0] STEP_M_LO = 3'd0;
    localparam logic [2:0] STEP_M_HI = 3'd1;
    localparam logic [2:0] STEP_S0M0 = 3'd2;
    localparam logic [2:0] STEP_S0M1 = 3'd3;
    localparam logic [2:0] STEP_S1M0 = 3'd4;
    localparam logic [2:0] STEP_S1M1 = 3'd5;

    // cosine points over 0..90 degrees in q30, truncating taylor series
    function automatic logic [TAB_W-1:0] build_cos_tab();
        logic [TAB_W-1:0]   tab;
        logic [63:0]        x, x2, term;
        logic signed [63:0] sum;
        tab = '0;
        for (int k = 0; k <= COS_ENTRIES; k++)
        begin
            x = HALF_PI_Q30 * 64'(k) / COS_ENTRIES;
            x2 = (x * x) >> 30;
            term = ONE_Q30;
            sum = signed'(ONE_Q30);
            for (int n = 1; n <= 10; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
                if (n[0])
                begin
                    sum = sum - signed'(term);
                end
                else
                begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            if (sum > signed'(ONE_Q30))
            begin
                sum = signed'(ONE_Q30);
            end
            tab[k * COS_W +: COS_W] = sum[COS_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [TAB_W-1:0] COS_TAB = build_cos_tab();

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_DIV_MEAN = 11'b00000000010,
        ST_FOLD     = 11'b00000000100,
        ST_DIV_IDX  = 11'b00000001000,
        ST_INTERP   = 11'b00000010000,
        ST_FRAC     = 11'b00000100000,
        ST_DIV_FRAC = 11'b00001000000,
        ST_MUL      = 11'b00010000000,
        ST_ACC      = 11'b00100000000,
        ST_TOTAL    = 11'b01000000000,
        ST_EMIT     = 11'b10000000000
    } back_state_t;

    back_state_t         state_reg;
    logic [63:0]         s_reg, p_reg, m_reg;
    logic [127:0]        acc_reg;
    logic [T_W-1:0]      t_reg;
    logic [COS_W-1:0]    lo_reg, hi_reg, cos_reg;
    logic [29:0]         frac_reg;
    logic                down_reg;
    logic [2:0]          step_reg;
    logic [55:0]         total_reg;
    logic                sat_reg, end_sat_reg;
    logic                ov_reg;
    logic [26:0]         q45_reg;
    rsp_word_t           out_reg;

    logic                div_start, div_done;
    logic [REC_LAT_W-1:0] div_dividend, div_quo;
    logic [REC_CNT_W-1:0] div_divisor;
    logic [REC_LAT_W-1:0] lat_mag;
    logic [31:0]         mean_mag, a_mod, a_fold;
    logic [IDX_W-1:0]    idx_lo, idx_hi;
    logic [COS_W-1:0]    diff;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;
    logic [59:0]         sum60;
    logic                rec_ring;
    logic [31:0]         recip_x, fold_hi, fold_rem;
    logic [63:0]         recip_p;

    gpa_divider #(.N_W(REC_LAT_W), .D_W(REC_CNT_W)) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(div_dividend),
        .divisor(div_divisor),
        .done(div_done),
        .quotient(div_quo)
    );

    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign rec_ring = !q_rec.is_end && (q_rec.count >= REC_CNT_W'(MIN_RING_VERTICES));
    assign lat_mag = q_rec.lat_sum[REC_LAT_W-1] ? REC_LAT_W'(-q_rec.lat_sum) : q_rec.lat_sum;

    always_comb
    begin
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                div_start = q_valid && rec_ring;
                div_dividend = lat_mag;
                div_divisor = q_rec.count;
            end
            default:
            begin
            end
        endcase
    end

    // divisions by 90 degrees: 2^24 shift then reciprocal of 45
    // interpolation product stays below 2^55, so bits 55:24 hold it
    always_comb
    begin
        recip_x = (state_reg == ST_FRAC) ? p_reg[FRAC_SHIFT+31:FRAC_SHIFT]
                                         : 32'(t_reg[T_W-1:FRAC_SHIFT]);
        recip_p = {32'd0, recip_x} * {32'd0, RECIP45};
        fold_hi = 32'(t_reg[T_W-1:FRAC_SHIFT]);
        fold_rem = fold_hi - 32'(q45_reg) * 32'(DEG90_ODD);
    end

    // mean latitude magnitude folded into 0..90 degrees
    always_comb
    begin
        mean_mag = div_quo[31:0];
        a_mod = (mean_mag >= DEG180) ? mean_mag - DEG180 : mean_mag;
        a_fold = (a_mod > DEG90) ? DEG180 - a_mod : a_mod;
        idx_lo = q45_reg[IDX_W-1:0];
        idx_hi = idx_lo + IDX_W'(1);
        diff = down_reg ? lo_reg - hi_reg : hi_reg - lo_reg;
    end

    // shared 32x32 multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_INTERP)
        begin
            mul_a = 32'(diff);
            mul_b = 32'(frac_reg);
        end
        else
        begin
            unique case (step_reg)
                STEP_M_LO:
                begin
                    mul_a = 32'(cos_reg);
                    mul_b = DEG_M_SQ[31:0];
                end
                STEP_M_HI:
                begin
                    mul_a = 32'(cos_reg);
                    mul_b = 32'(DEG_M_SQ[33:32]);
                end
                STEP_S0M0:
                begin
                    mul_a = s_reg[31:0];
                    mul_b = m_reg[31:0];
                end
                STEP_S0M1:
                begin
                    mul_a = s_reg[31:0];
                    mul_b = m_reg[63:32];
                end
                STEP_S1M0:
                begin
                    mul_a = s_reg[63:32];
                    mul_b = m_reg[31:0];
                end
                STEP_S1M1:
                begin
                    mul_a = s_reg[63:32];
                    mul_b = m_reg[63:32];
                end
                default:
                begin
                end
            endcase
        end
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
        sum60 = {4'd0, total_reg} + {1'b0, acc_reg[127:69]};
    end

    assign rsp.valid = ov_reg;
    assign rsp.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            sat_reg <= 1'b0;
            ov_reg <= 1'b0;
            step_reg <= STEP_M_LO;
        end
        else
        begin
            if (ov_reg && rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_rec.is_end)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else if (rec_ring)
                        begin
                            state_reg <= ST_DIV_MEAN;
                        end
                    end
                end
                ST_DIV_MEAN:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    state_reg <= ST_DIV_IDX;
                end
                ST_DIV_IDX:
                begin
                    step_reg <= STEP_M_LO;
                    state_reg <= (q45_reg >= 27'(COS_ENTRIES)) ? ST_MUL : ST_INTERP;
                end
                ST_INTERP:
                begin
                    state_reg <= ST_FRAC;
                end
                ST_FRAC:
                begin
                    state_reg <= ST_DIV_FRAC;
                end
                ST_DIV_FRAC:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (step_reg == STEP_S1M1)
                    begin
                        state_reg <= ST_TOTAL;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_TOTAL:
                begin
                    if (sum60 > 60'(TOTAL_MAX))
                    begin
                        total_reg <= TOTAL_MAX;
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        total_reg <= sum60[55:0];
                    end
                    state_reg <= ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (!ov_reg || rsp.ready)
                    begin
                        ov_reg <= 1'b1;
                        total_reg <= '0;
                        sat_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                s_reg <= q_rec.cross_sum[63] ? 64'(-q_rec.cross_sum) : q_rec.cross_sum;
                end_sat_reg <= q_rec.sat;
            end
            ST_DIV_MEAN:
            begin
                t_reg <= T_W'(a_fold[29:0]) * T_W'(COS_ENTRIES);
            end
            ST_FOLD:
            begin
                q45_reg <= recip_p[63:RECIP_SHIFT];
            end
            ST_DIV_IDX:
            begin
                frac_reg <= {fold_rem[5:0], t_reg[FRAC_SHIFT-1:0]};
                cos_reg <= COS_TAB[COS_ENTRIES * COS_W +: COS_W];
                lo_reg <= COS_TAB[idx_lo * COS_W +: COS_W];
                hi_reg <= COS_TAB[idx_hi * COS_W +: COS_W];
                down_reg <= COS_TAB[idx_hi * COS_W +: COS_W] <= COS_TAB[idx_lo * COS_W +: COS_W];
            end
            ST_INTERP:
            begin
                p_reg <= mul_p;
            end
            ST_FRAC:
            begin
                q45_reg <= recip_p[63:RECIP_SHIFT];
            end
            ST_DIV_FRAC:
            begin
                cos_reg <= down_reg ? lo_reg - COS_W'(q45_reg) : lo_reg + COS_W'(q45_reg);
            end
            ST_MUL:
            begin
                p_reg <= mul_p;
            end
            ST_ACC:
            begin
                unique case (step_reg)
                    STEP_M_LO: m_reg <= p_reg;
                    STEP_M_HI: m_reg <= m_reg + {p_reg[31:0], 32'd0};
                    STEP_S0M0: acc_reg <= {64'd0, p_reg};
                    STEP_S0M1: acc_reg <= acc_reg + {32'd0, p_reg, 32'd0};
                    STEP_S1M0: acc_reg <= acc_reg + {32'd0, p_reg, 32'd0};
                    STEP_S1M1: acc_reg <= acc_reg + {p_reg, 64'd0};
                    default: acc_reg <= acc_reg;
                endcase
            end
            ST_EMIT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    out_reg.area_sq_m <= total_reg;
                    out_reg.area_saturated <= sat_reg || end_sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/core/geo_polygon_area.sv */
// polygon area over an equirectangular projection. the req channel carries one word
// per vertex (longitude, latitude in 2^-23 degree, ring_last on the ring's closing
// vertex) and an end-of-polygon word; the rsp channel returns one word per end of
// polygon: total area in 1/256 square metre, saturated at 2^56-1, with a flag for any
// limit hit on the way. vertices are taken one per cycle through a two-stage front
// that forms the relative coordinates and the shoelace cross products. closed rings
// and polygon ends pass a four-deep queue to a back sequencer, which per ring of
// three or more vertices runs one division for the mean latitude, a reciprocal
// multiply for the two divisions by 90 degrees (table index and interpolation)
// and six steps of a shared 32x32 multiplier; an end word goes to an emit state
// that holds through any output stall. the front stalls only when the queue is
// full, so rings longer than about 70 vertices stream at one vertex per cycle.
// there is no clearing pass after reset.
module geo_polygon_area #(
    parameter int MAX_RING_VERTICES = gpa_pkg::MAX_RING_VERTICES_DEF,
    parameter int COS_TABLE_ENTRIES = gpa_pkg::COS_TABLE_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    gpa_stream_if.sink   req,
    gpa_stream_if.source rsp
);
    import gpa_pkg::*;

    // ring records between front and back
    ring_rec_t push_rec, pop_rec;
    logic      push, q_full, pop, q_valid;

    // front: vertex words in, ring and end records out
    gpa_front #(.MAX_RING_VERTICES(MAX_RING_VERTICES)) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .q_full(q_full),
        .push(push),
        .push_rec(push_rec)
    );

    // decoupling queue
    gpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_rec(push_rec),
        .full(q_full),
        .pop(pop),
        .not_empty(q_valid),
        .pop_rec(pop_rec)
    );

    // back: cosine, scaling, polygon total, result word
    gpa_back #(.COS_ENTRIES(COS_TABLE_ENTRIES)) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_rec(pop_rec),
        .q_pop(pop),
        .rsp(rsp)
    );

endmodule

/* rtl/core/gpa_checker.sv */
module gpa_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_type,
    input logic rsp_valid,
    input logic rsp_ready
);
    import gpa_pkg::*;

    logic [4:0] owed_reg;
    logic       end_in, rsp_out;

    assign end_in = req_valid && req_ready && (req_type == REQ_END);
    assign rsp_out = rsp_valid && rsp_ready;

    // results still owed for accepted end words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= '0;
        end
        else if (end_in && !rsp_out)
        begin
            owed_reg <= owed_reg + 5'd1;
        end
        else if (rsp_out && !end_in)
        begin
            owed_reg <= owed_reg - 5'd1;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> owed_reg != 5'd0)
        else $error("result word without an end of polygon");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_out && owed_reg == 5'd1 && !end_in |=> !rsp_valid)
        else $error("result word repeated");

endmodule

bind geo_polygon_area gpa_checker u_gpa_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .req_type(req.data.req_type),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready)
);
